@@ src/point_proximity_clusterer_top_defines.svh @@
// Assertion macros shared by the point proximity clusterer checkers.
`ifndef POINT_PROXIMITY_CLUSTERER_TOP_DEFINES_SVH
`define POINT_PROXIMITY_CLUSTERER_TOP_DEFINES_SVH

// Property that is checked only while reset is low.
`define PPC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that must also hold through reset.
`define PPC_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ppc_pkg.sv @@
// Types and constants of the point proximity clusterer.
`default_nettype none
package ppc_pkg;

  localparam int COORD_W   = 10;
  localparam int CLUSTER_W = 8;
  localparam int NEXT_W    = CLUSTER_W + 1;
  localparam int SQ_W      = 2 * COORD_W;

  localparam logic [COORD_W-1:0] RADIUS_RESET = 10'd50;
  localparam logic               RADIUS_IDX   = 1'b0;

  typedef struct packed {
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [CLUSTER_W-1:0] cluster;
  } point_t;

  typedef struct packed {
    logic                 hit;
    logic [CLUSTER_W-1:0] cluster;
  } hit_t;

endpackage
`default_nettype wire

@@ src/ppc_cell.sv @@
// One storage cell of the rotating point ring.
`default_nettype none
module ppc_cell (
  input  wire             clk,
  input  wire             shift,
  input  wire             load,
  input  ppc_pkg::point_t load_pt,
  input  ppc_pkg::point_t next_pt,
  output ppc_pkg::point_t pt
);
  import ppc_pkg::*;

  // A load stores a new point; otherwise, while shift is high, the ring moves one place per cycle.
  always_ff @(posedge clk) begin
    if (load) begin
      pt <= load_pt;
    end else if (shift) begin
      pt <= next_pt;
    end
  end

endmodule
`default_nettype wire

@@ src/ppc_dist.sv @@
// Three-stage squared-distance compare of the query against one stored point.
`default_nettype none
module ppc_dist (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          vld,
  input  ppc_pkg::point_t              pt,
  input  wire [ppc_pkg::COORD_W-1:0]   qx,
  input  wire [ppc_pkg::COORD_W-1:0]   qy,
  input  wire [ppc_pkg::SQ_W-1:0]      r2,
  output ppc_pkg::hit_t                res
);
  import ppc_pkg::*;

  logic [COORD_W-1:0]   dxa, dya;
  logic [CLUSTER_W-1:0] ca, cb, cc;
  logic                 va, vb, hc;
  logic [SQ_W-1:0]      sqx, sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      hc <= 1'b0;
    end else begin
      va <= vld;
      vb <= va;
      hc <= vb && (({1'b0, sqx} + {1'b0, sqy}) < {1'b0, r2});
    end
  end

  always_ff @(posedge clk) begin
    dxa <= (qx >= pt.x) ? (qx - pt.x) : (pt.x - qx);
    dya <= (qy >= pt.y) ? (qy - pt.y) : (pt.y - qy);
    ca  <= pt.cluster;
    sqx <= SQ_W'(dxa) * SQ_W'(dxa);
    sqy <= SQ_W'(dya) * SQ_W'(dya);
    cb  <= ca;
    cc  <= cb;
  end

  assign res.hit     = hc;
  assign res.cluster = cc;

endmodule
`default_nettype wire

@@ src/point_proximity_clusterer_top.sv @@
// Top level of the point proximity clusterer: point ring, scan control, ports.
`default_nettype none
// Usage
// Each transfer on the slave stream (s_tvalid, s_tready, s_tdata) carries one
// point. The block compares it against every stored point and joins it to the
// lowest-numbered cluster that has a member closer than the radius, or opens a
// new cluster. One result per point leaves on the master stream (m_tvalid,
// m_tready, m_tdata) with the cluster number, a new-cluster flag and a drop
// flag that is set when the point store is full or cluster numbers run out.
// The stored points sit in a ring of MAX_POINTS cells that rotates once per
// point past a single three-stage distance unit. After the ring scan (ST_SCAN)
// and the drain of the unit (ST_DRAIN) the result is registered in ST_FIN; a
// point that arrives with the store full goes straight to ST_FIN. One point is
// in work at a time: the next point can be taken the cycle after a result is
// registered.
// The radius register sits at byte address 0 of the APB port and should be
// written only while the block is idle. Reset empties the store, restarts
// cluster numbering at zero and sets the radius to 50. When the receiver
// stalls, the result waits in the output register; the next point is still
// taken, and its result is held back until the previous one has gone.
module point_proximity_clusterer_top #(
  parameter int MAX_POINTS = 256
) (
  input  wire         clk,
  input  wire         rst,
  // s_tdata: x_coord [9:0], y_coord [19:10], zero fill [23:20]
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,
  // m_tdata: cluster_id [7:0], new_cluster [8], dropped [9], zero fill [15:10]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ppc_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // Last drain count: ST_DRAIN is left when drain_cnt reaches it, once the final compare has landed.
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  logic [1:0]           state;
  logic [IW-1:0]        step;
  logic [1:0]           drain_cnt;
  logic [CW-1:0]        count;
  logic [NEXT_W-1:0]    next_cluster;
  logic [COORD_W-1:0]   radius;
  logic [SQ_W-1:0]      r2;
  logic [COORD_W-1:0]   qx, qy;
  logic                 full_flag;
  logic                 found;
  logic [CLUSTER_W-1:0] best;
  logic [CLUSTER_W-1:0] out_cluster;
  logic                 out_new, out_drop;

  point_t               ring [MAX_POINTS];
  point_t               load_pt;
  hit_t                 hit;
  logic                 shift, scan_vld, out_free, drop, store_now, take;
  logic [CLUSTER_W-1:0] cluster_sel;

  // No point is taken while reset is held.
  assign s_tready = (state == ST_IDLE) && !rst;
  assign take     = s_tvalid && s_tready;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == RADIUS_IDX) ? {{(32 - COORD_W){1'b0}}, radius} : 32'd0;
  assign m_tdata  = {6'd0, out_drop, out_new, out_cluster};

  // During a scan the ring turns once; cell 0 feeds the distance unit, and
  // only positions below the fill count hold stored points.
  assign shift    = (state == ST_SCAN);
  assign scan_vld = shift && (CW'(step) < count);

  // A point is dropped when the store is full, or when it needs a cluster
  // and every cluster number is taken.
  assign out_free    = !m_tvalid || m_tready;
  assign drop        = full_flag || (!found && next_cluster[NEXT_W-1]);
  assign cluster_sel = found ? best : next_cluster[CLUSTER_W-1:0];
  assign store_now   = (state == ST_FIN) && out_free && !drop;

  assign load_pt.x       = qx;
  assign load_pt.y       = qy;
  assign load_pt.cluster = cluster_sel;

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_ring
    ppc_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .load    (store_now && (count == CW'(k))),
      .load_pt (load_pt),
      .next_pt (ring[(k + 1) % MAX_POINTS]),
      .pt      (ring[k])
    );
  end

  ppc_dist u_dist (
    .clk (clk),
    .rst (rst),
    .vld (scan_vld),
    .pt  (ring[0]),
    .qx  (qx),
    .qy  (qy),
    .r2  (r2),
    .res (hit)
  );

  // Radius register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RADIUS_IDX)) begin
      radius <= pwdata[COORD_W-1:0];
    end
  end

  // Query registers; the squared radius is taken once per point.
  always_ff @(posedge clk) begin
    if (take) begin
      qx <= s_tdata[COORD_W-1:0];
      qy <= s_tdata[2*COORD_W-1:COORD_W];
      r2 <= SQ_W'(radius) * SQ_W'(radius);
    end
  end

  // Control, best-match tracking and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      drain_cnt    <= '0;
      count        <= '0;
      next_cluster <= '0;
      full_flag    <= 1'b0;
      found        <= 1'b0;
      best         <= '0;
      m_tvalid     <= 1'b0;
      out_cluster  <= '0;
      out_new      <= 1'b0;
      out_drop     <= 1'b0;
    end else begin
      // In the final state the output register is reloaded instead.
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end

      if (take) begin
        found <= 1'b0;
      end else if (hit.hit && (!found || (hit.cluster < best))) begin
        found <= 1'b1;
        best  <= hit.cluster;
      end

      case (state)
        ST_IDLE: begin
          if (take) begin
            step      <= '0;
            full_flag <= (count == CW'(MAX_POINTS));
            state     <= (count == CW'(MAX_POINTS)) ? ST_FIN : ST_SCAN;
          end
        end
        ST_SCAN: begin
          step <= step + 1'b1;
          if (step == IW'(MAX_POINTS - 1)) begin
            drain_cnt <= '0;
            state     <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt + 1'b1;
          if (drain_cnt == DRAIN_LAST) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid    <= 1'b1;
            out_drop    <= drop;
            out_new     <= !drop && !found;
            out_cluster <= drop ? '0 : cluster_sel;
            if (!drop) begin
              count <= count + 1'b1;
              if (!found) begin
                next_cluster <= next_cluster + 1'b1;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/ppc_checker.sv @@
// Port-level checks of the point proximity clusterer and their binding.
`default_nettype none
`include "point_proximity_clusterer_top_defines.svh"
module ppc_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [15:0] m_tdata,
  input wire        psel,
  input wire        penable,
  input wire        pwrite,
  input wire [2:0]  paddr,
  input wire [31:0] pwdata,
  input wire [31:0] prdata,
  input wire        pready
);

  `PPC_ASSERT(a_out_hold, clk, rst,
              m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
              "result changed while stalled")
  `PPC_ASSERT_RST(a_reset_empty, clk, rst |=> !m_tvalid,
                  "result valid right after reset")
  `PPC_ASSERT(a_drop_clean, clk, rst,
              m_tvalid && m_tdata[9] |-> m_tdata[8:0] == 9'd0,
              "dropped result carries a cluster")
  `PPC_ASSERT(a_busy_after_take, clk, rst, s_tvalid && s_tready |=> !s_tready,
              "second point taken while one is in work")
  `PPC_ASSERT(a_radius_readback, clk, rst,
              psel && penable && pwrite && pready && !paddr[2] |=>
                prdata == {22'd0, $past(pwdata[9:0])},
              "radius readback differs from write")

endmodule

bind point_proximity_clusterer_top ppc_checker u_ppc_checker (.*);
`default_nettype wire
